// File: hdl/spq4_pkg.sv
// ----------------------------------------------------------------------------
// spq4_pkg: shared definitions for the strict priority four class server
// Sizes, opcodes and defaults used by the server and its testbench.
// ----------------------------------------------------------------------------
package spq4_pkg;

	localparam int NUM_CLASSES       = 4;
	localparam int CLASS_W           = 2;
	localparam int DUR_W             = 16;
	localparam int QUEUE_DEPTH_DEF   = 16;
	localparam int ID_WIDTH_DEF      = 16;

	localparam logic FUNC_ARRIVE = 1'b0;
	localparam logic FUNC_TICK   = 1'b1;

endpackage

// File: hdl/spq4_ram.sv
// ----------------------------------------------------------------------------
// spq4_ram: generic single write port RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
module spq4_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hdl/strict_priority_four_class_server.sv
// Throughput: one beat per cycle, set by the input register, the job store
//   read port and the result register; back pressure stalls the whole pipe.
// Reset: arst_n clears queue heads and counts, the server state and all
//   valid flags; the job store itself is never cleared, only written.
// ----------------------------------------------------------------------------
// strict_priority_four_class_server: four FIFO classes feeding one server
// Arrivals append to their class queue, dropped when full; ticks run down the
// current job; a free server takes the head of the lowest-index non-empty class.
// ----------------------------------------------------------------------------
module strict_priority_four_class_server #(
	parameter int QUEUE_DEPTH = spq4_pkg::QUEUE_DEPTH_DEF,
	parameter int ID_WIDTH    = spq4_pkg::ID_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         func,
	input  logic [ID_WIDTH-1:0]          job_id,
	input  logic [spq4_pkg::CLASS_W-1:0] priority_class,
	input  logic [spq4_pkg::DUR_W-1:0]   service_ticks,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         answered,
	output logic [ID_WIDTH-1:0]          answered_id,
	output logic [spq4_pkg::CLASS_W-1:0] answered_class,
	output logic                         dropped,
	output logic                         server_busy,
	output logic                         jobs_pending
);

	localparam int NC     = spq4_pkg::NUM_CLASSES;
	localparam int CW     = spq4_pkg::CLASS_W;
	localparam int DW     = spq4_pkg::DUR_W;
	localparam int POS_W  = $clog2(QUEUE_DEPTH);
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W  = CNT_W + 1;
	localparam int DEPTH  = NC * QUEUE_DEPTH;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int MEM_W  = ID_WIDTH + DW;

	// input register
	logic                valid_s1;
	logic                func_s1;
	logic [ID_WIDTH-1:0] id_s1;
	logic [CW-1:0]       cls_s1;
	logic [DW-1:0]       dur_s1;

	// result register
	logic          valid_s2;
	logic          ans_s2;
	logic [CW-1:0] cls_s2;
	logic          drop_s2;
	logic          busy_s2;
	logic          pend_s2;

	// scheduler state
	logic [POS_W-1:0] head_q [NC];
	logic [CNT_W-1:0] cnt_q  [NC];
	logic             busy_q;
	logic [DW-1:0]    ticks_q;
	logic             load_q;

	logic [POS_W-1:0] head_d [NC];
	logic [CNT_W-1:0] cnt_d  [NC];
	logic             busy_d;
	logic [DW-1:0]    ticks_d;
	logic [DW-1:0]    eff_ticks;
	logic [DW-1:0]    rdur;

	logic              en;
	logic              fire;
	logic              start;
	logic              drop;
	logic              found;
	logic              pend;
	logic [CW-1:0]     pick;
	logic              we;
	logic              re;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] raddr;
	logic [SUM_W-1:0]  tail;
	logic [MEM_W-1:0]  rdata;

	assign en       = !valid_s2 || out_ready;
	assign fire     = valid_s1 && en;
	assign in_ready = !valid_s1 || en;

	assign rdur      = rdata[DW-1:0];
	assign eff_ticks = load_q ? ((rdur == '0) ? DW'(1) : rdur) : ticks_q;

	always_comb begin
		for (int c = 0; c < NC; c++) begin
			head_d[c] = head_q[c];
			cnt_d[c]  = cnt_q[c];
		end
		busy_d  = busy_q;
		ticks_d = eff_ticks;
		start   = 1'b0;
		drop    = 1'b0;
		found   = 1'b0;
		pick    = '0;
		we      = 1'b0;
		tail    = SUM_W'(head_q[cls_s1]) + SUM_W'(cnt_q[cls_s1]);
		if (tail >= SUM_W'(QUEUE_DEPTH)) begin
			tail = tail - SUM_W'(QUEUE_DEPTH);
		end
		if (fire) begin
			if (func_s1 == spq4_pkg::FUNC_ARRIVE) begin
				if (cnt_q[cls_s1] >= CNT_W'(QUEUE_DEPTH)) begin
					drop = 1'b1;
				end else begin
					we             = 1'b1;
					cnt_d[cls_s1]  = cnt_q[cls_s1] + CNT_W'(1);
				end
			end else begin
				if (busy_q) begin
					if (eff_ticks != '0) begin
						ticks_d = eff_ticks - DW'(1);
					end
					if (ticks_d == '0) begin
						busy_d = 1'b0;
					end
				end
				if (!busy_d) begin
					for (int c = 0; c < NC; c++) begin
						if (!found && cnt_q[c] != '0) begin
							found = 1'b1;
							pick  = CW'(c);
						end
					end
					if (found) begin
						start        = 1'b1;
						busy_d       = 1'b1;
						cnt_d[pick]  = cnt_q[pick] - CNT_W'(1);
						head_d[pick] = (head_q[pick] == POS_W'(QUEUE_DEPTH - 1)) ? '0
							: head_q[pick] + POS_W'(1);
					end
				end
			end
		end
		pend = 1'b0;
		for (int c = 0; c < NC; c++) begin
			pend = pend || (cnt_d[c] != '0);
		end
	end

	assign re    = start;
	assign waddr = ADDR_W'(cls_s1) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail);
	assign raddr = ADDR_W'(pick) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head_q[pick]);

	spq4_ram #(
		.WIDTH(MEM_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata({id_s1, dur_s1}),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NC; c++) begin
				head_q[c] <= '0;
				cnt_q[c]  <= '0;
			end
			busy_q   <= 1'b0;
			ticks_q  <= '0;
			load_q   <= 1'b0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			for (int c = 0; c < NC; c++) begin
				head_q[c] <= head_d[c];
				cnt_q[c]  <= cnt_d[c];
			end
			busy_q  <= busy_d;
			ticks_q <= ticks_d;
			load_q  <= start;
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (en) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_s1 <= func;
			id_s1   <= job_id;
			cls_s1  <= priority_class;
			dur_s1  <= service_ticks;
		end
		if (fire) begin
			ans_s2  <= start;
			cls_s2  <= start ? pick : '0;
			drop_s2 <= drop;
			busy_s2 <= busy_d;
			pend_s2 <= pend;
		end
	end

	assign out_valid      = valid_s2;
	assign answered       = ans_s2;
	assign answered_id    = ans_s2 ? rdata[DW +: ID_WIDTH] : '0;
	assign answered_class = cls_s2;
	assign dropped        = drop_s2;
	assign server_busy    = busy_s2;
	assign jobs_pending   = pend_s2;

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for strict_priority_four_class_server
// Directed and random arrival/tick beats under several idle and stall mixes;
// a scoreboard model of the four class queues and the server predicts every
// result beat, which is checked in order as one packed value.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int DEPTH     = spq4_pkg::QUEUE_DEPTH_DEF;
	localparam int IDW       = spq4_pkg::ID_WIDTH_DEF;
	localparam int NCLS      = spq4_pkg::NUM_CLASSES;
	localparam int MAX_CYCLE = 400000;

	typedef struct packed {
		logic           answered;
		logic [IDW-1:0] answered_id;
		logic [1:0]     answered_class;
		logic           dropped;
		logic           server_busy;
		logic           jobs_pending;
	} sched_result_t;

	logic           clk            = 1'b0;
	logic           arst_n         = 1'b0;
	logic           in_valid       = 1'b0;
	logic           func           = spq4_pkg::FUNC_ARRIVE;
	logic [IDW-1:0] job_id         = '0;
	logic [1:0]     priority_class = '0;
	logic [15:0]    service_ticks  = '0;
	logic           out_ready      = 1'b0;
	logic           in_ready;
	logic           out_valid;
	logic           answered;
	logic [IDW-1:0] answered_id;
	logic [1:0]     answered_class;
	logic           dropped;
	logic           server_busy;
	logic           jobs_pending;

	sched_result_t  due_results[$];
	int             mismatch_count = 0;
	int             cycle_count    = 0;
	int             send_idle_pct  = 0;
	int             recv_stall_pct = 0;

	// scoreboard copy of the queues and server
	logic [IDW-1:0] slot_id[NCLS][DEPTH];
	logic [15:0]    slot_dur[NCLS][DEPTH];
	int             cls_head[NCLS];
	int             cls_count[NCLS];
	bit             srv_busy   = 1'b0;
	int             hold_ticks = 0;

	strict_priority_four_class_server dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .job_id(job_id), .priority_class(priority_class),
		.service_ticks(service_ticks),
		.out_valid(out_valid), .out_ready(out_ready),
		.answered(answered), .answered_id(answered_id),
		.answered_class(answered_class), .dropped(dropped),
		.server_busy(server_busy), .jobs_pending(jobs_pending)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= MAX_CYCLE) begin
			$display("[strict_priority_four_class_server] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic void serve_step(logic f, logic [IDW-1:0] id, logic [1:0] cls,
			logic [15:0] dur);
		sched_result_t r;
		int            pos;
		bit            found;
		r     = '0;
		found = 1'b0;
		if (f == spq4_pkg::FUNC_ARRIVE) begin
			if (cls_count[cls] >= DEPTH) begin
				r.dropped = 1'b1;
			end else begin
				pos = (cls_head[cls] + cls_count[cls]) % DEPTH;
				slot_id[cls][pos]  = id;
				slot_dur[cls][pos] = dur;
				cls_count[cls]++;
			end
		end else begin
			if (srv_busy) begin
				if (hold_ticks > 0) hold_ticks--;
				if (hold_ticks == 0) srv_busy = 1'b0;
			end
			if (!srv_busy) begin
				for (int c = 0; c < NCLS; c++) begin
					if (!found && cls_count[c] != 0) begin
						found            = 1'b1;
						pos              = cls_head[c];
						r.answered       = 1'b1;
						r.answered_id    = slot_id[c][pos];
						r.answered_class = c[1:0];
						hold_ticks       = (slot_dur[c][pos] == 0) ? 1 : int'(slot_dur[c][pos]);
						srv_busy         = 1'b1;
						cls_head[c]      = (pos + 1) % DEPTH;
						cls_count[c]--;
					end
				end
			end
		end
		r.server_busy = srv_busy;
		for (int c = 0; c < NCLS; c++)
			if (cls_count[c] != 0) r.jobs_pending = 1'b1;
		due_results.insert(due_results.size(), r);
	endfunction

	function automatic int draw_gap(int pct);
		int g;
		g = 0;
		while (g < 30 && $urandom_range(99) < pct) g++;
		return g;
	endfunction

	// called at a rising edge; returns at the edge that takes the beat
	task automatic send_beat(logic f, logic [IDW-1:0] id, logic [1:0] cls, logic [15:0] dur);
		int gap;
		gap = draw_gap(send_idle_pct);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		func           <= f;
		job_id         <= id;
		priority_class <= cls;
		service_ticks  <= dur;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		serve_step(f, id, cls, dur);
	endtask

	task automatic send_tick();
		send_beat(spq4_pkg::FUNC_TICK, IDW'($urandom), 2'($urandom), 16'($urandom));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// result checker: a beat seen at the falling edge is taken at the next rise
	always @(negedge clk) begin
		sched_result_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = {answered, answered_id, answered_class, dropped, server_busy, jobs_pending};
			if (due_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result beat: %p", got);
			end else begin
				want = due_results.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	task automatic test_idle_tick();
		send_tick();
		send_tick();
	endtask

	task automatic test_priority_order();
		send_beat(spq4_pkg::FUNC_ARRIVE, 16'hFFFF, 2'd3, 16'd0);
		send_beat(spq4_pkg::FUNC_ARRIVE, 16'h0000, 2'd2, 16'd1);
		send_beat(spq4_pkg::FUNC_ARRIVE, 16'h5A5A, 2'd1, 16'd2);
		send_beat(spq4_pkg::FUNC_ARRIVE, 16'hA5A5, 2'd0, 16'd3);
		send_beat(spq4_pkg::FUNC_ARRIVE, 16'h8001, 2'd0, 16'd0);
		repeat (9) send_tick();
	endtask

	task automatic test_queue_full();
		for (int i = 0; i < DEPTH + 1; i++)
			send_beat(spq4_pkg::FUNC_ARRIVE, IDW'(16'h7F00 + i), 2'd1,
				16'($urandom_range(1)));
	endtask

	task automatic test_random(int s_pct, int r_pct, int n);
		int arrive_pct;
		wait_drained();
		send_idle_pct  = s_pct;
		recv_stall_pct = r_pct;
		for (int i = 0; i < n; i++) begin
			// alternate filling and draining stretches
			arrive_pct = ((i / 64) % 2 == 0) ? 65 : 35;
			if ($urandom_range(99) < arrive_pct)
				send_beat(spq4_pkg::FUNC_ARRIVE, IDW'($urandom), 2'($urandom_range(3)),
					($urandom_range(9) == 0) ? 16'($urandom_range(12)) : 16'($urandom_range(3)));
			else
				send_tick();
		end
	endtask

	task automatic test_long_service();
		wait_drained();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		// empty all queues first so the long job starts
		while (srv_busy || cls_count[0] + cls_count[1] + cls_count[2] + cls_count[3] != 0)
			send_tick();
		wait_drained();
		send_beat(spq4_pkg::FUNC_ARRIVE, IDW'($urandom), 2'd2, 16'hFFFF);
		send_beat(spq4_pkg::FUNC_ARRIVE, IDW'($urandom), 2'd0, 16'($urandom));
		repeat (6) send_tick();
	endtask

	initial begin
		for (int c = 0; c < NCLS; c++) begin
			cls_head[c]  = 0;
			cls_count[c] = 0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_tick();
		test_priority_order();
		test_queue_full();
		test_random(0, 0, 400);
		test_random(46, 0, 400);
		test_random(0, 46, 400);
		test_random(35, 35, 400);
		test_long_service();
		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && due_results.size() == 0)
			$display("[strict_priority_four_class_server] OK");
		else
			$display("[strict_priority_four_class_server] ERROR");
		$finish;
	end

endmodule
